// ===== src/lgs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lgs_pkg;

	// Default grid bounds
	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;

	// Size registers
	localparam int CFG_W = 7;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;
	localparam int MIN_SIZE = 3;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd1;

	// Item fields
	localparam int OP_W = 2;
	localparam int IDX_W = 6;
	localparam int IN_DATA_W = 16;
	localparam int OUT_DATA_W = 8;

	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ = 2'd1;
	localparam logic [OP_W-1:0] OP_STEP = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE = 2'd3;

	// Neighbor counts of the life rule
	localparam logic [3:0] LIFE_BIRTH = 4'd3;
	localparam logic [3:0] LIFE_KEEP = 4'd2;

endpackage

`default_nettype wire

// ===== src/life_grid_generation_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Fields (tdata from bit 0 up)
// s_*      in         op[1:0], row[7:2], col[13:8], cell_value[14], zero pad to 16 bits
// m_*      out        read_cell[0], status[1], zero pad to 8 bits
// cfg_*    in         index 0 grid_rows, index 1 grid_cols, 7-bit data
//
// One item is in flight at a time; the next is taken while a result waits in m_*.
// Write or read of a cell: row read, modify or pick, then the result register.
// Advance: a one-row-per-cycle sweep through the grid memory, plus the wrap rows
// and the zeroing of rows past the size in use.
// After reset a clearing pass writes MAX_ROWS rows before the first item is taken.
// A stall on m_* holds the finished result and the next item's result waits in the result register.

module life_grid_generation_step #(
	parameter int MAX_ROWS = lgs_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = lgs_pkg::DEF_MAX_COLS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Item in
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [lgs_pkg::IN_DATA_W-1:0]    s_tdata,   // op, row, col, cell_value
	// Result out
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic      [lgs_pkg::OUT_DATA_W-1:0]   m_tdata,   // read_cell, status
	// Size registers
	input  wire logic                             cfg_we,
	input  wire logic [lgs_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  wire logic [lgs_pkg::CFG_W-1:0]        cfg_wdata
);
	import lgs_pkg::*;

	localparam int AW = $clog2(MAX_ROWS);
	localparam int RW = $clog2(MAX_ROWS + 1);
	localparam int CAW = $clog2(MAX_COLS);
	localparam int CW = $clog2(MAX_COLS + 1);
	localparam int SRW = (RW > CFG_W) ? RW : CFG_W;
	localparam int SCW = (CW > CFG_W) ? CW : CFG_W;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_CELL, ST_GEN, ST_GTAIL, ST_GLAST, ST_GZERO, ST_RESP
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0] grid_rows_q, grid_cols_q;
	logic [RW-1:0]    nr;
	logic [CW-1:0]    nc;
	logic [SRW-1:0]   rows_ext;
	logic [SCW-1:0]   cols_ext;

	logic [OP_W-1:0]  in_op;
	logic [IDX_W-1:0] in_row, in_col;
	logic             in_val, in_range, s_fire;

	logic             wr_op_q, val_q;
	logic [AW-1:0]    addr_q;
	logic [CAW-1:0]   col_q;
	logic [RW-1:0]    k_q, k_s1, zrow_q;
	logic             gen_v_s1;
	logic [MAX_COLS-1:0] up_q, cur_q, first_q;
	logic             res_rd_q, res_st_q;
	logic             out_valid_q, out_rd_q, out_st_q;

	logic                mem_we, mem_re;
	logic [AW-1:0]       mem_waddr, mem_raddr;
	logic [MAX_COLS-1:0] mem_wdata, mem_rdata, rule_dn, rule_row, cell_row;
	logic [RW-1:0]       nr_m1, k_m1, k_m2;

	// Size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= SIZE_RESET;
			grid_cols_q <= SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_GRID_ROWS: grid_rows_q <= cfg_wdata;
				REG_GRID_COLS: grid_cols_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Clamp sizes to the grid bounds
	assign rows_ext = SRW'(grid_rows_q);
	assign cols_ext = SCW'(grid_cols_q);
	assign nr = (rows_ext < SRW'(MIN_SIZE)) ? RW'(MIN_SIZE)
		: (rows_ext > SRW'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(rows_ext);
	assign nc = (cols_ext < SCW'(MIN_SIZE)) ? CW'(MIN_SIZE)
		: (cols_ext > SCW'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(cols_ext);

	// Unpack the item
	assign in_op = s_tdata[1:0];
	assign in_row = s_tdata[7:2];
	assign in_col = s_tdata[13:8];
	assign in_val = s_tdata[14];
	assign in_range = (32'(in_row) < 32'(nr)) && (32'(in_col) < 32'(nc));

	assign s_tready = (state_q == ST_IDLE);
	assign s_fire = s_tvalid && s_tready;

	assign nr_m1 = nr - RW'(1);
	assign k_m1 = k_q - RW'(1);
	assign k_m2 = k_s1 - RW'(2);

	// New row from the three-row window
	assign rule_dn = (state_q == ST_GLAST) ? first_q : mem_rdata;

	lgs_row_rule #(
		.MAX_COLS(MAX_COLS)
	) u_rule (
		.up   (up_q),
		.cur  (cur_q),
		.dn   (rule_dn),
		.ncols(nc),
		.nxt  (rule_row)
	);

	// Patch one cell of the fetched row
	always_comb begin
		cell_row = mem_rdata;
		cell_row[col_q] = val_q;
	end

	// Memory port selection
	always_comb begin
		mem_re = 1'b0;
		mem_raddr = '0;
		mem_we = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		if (s_fire && in_range && ((in_op == OP_WRITE) || (in_op == OP_READ))) begin
			mem_re = 1'b1;
			mem_raddr = AW'(in_row);
		end
		if (state_q == ST_GEN) begin
			mem_re = 1'b1;
			mem_raddr = (k_q == '0) ? nr_m1[AW-1:0] : k_m1[AW-1:0];
		end
		if (gen_v_s1 && (k_s1 >= RW'(2))) begin
			mem_we = 1'b1;
			mem_waddr = k_m2[AW-1:0];
			mem_wdata = rule_row;
		end
		if (state_q == ST_GLAST) begin
			mem_we = 1'b1;
			mem_waddr = nr_m1[AW-1:0];
			mem_wdata = rule_row;
		end
		if ((state_q == ST_CELL) && wr_op_q) begin
			mem_we = 1'b1;
			mem_waddr = addr_q;
			mem_wdata = cell_row;
		end
		if ((state_q == ST_CLEAR) || (state_q == ST_GZERO)) begin
			mem_we = 1'b1;
			mem_waddr = zrow_q[AW-1:0];
			mem_wdata = '0;
		end
	end

	lgs_ram #(
		.WIDTH(MAX_COLS),
		.DEPTH(MAX_ROWS)
	) u_grid (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			zrow_q <= '0;
			k_q <= '0;
			k_s1 <= '0;
			gen_v_s1 <= 1'b0;
			res_rd_q <= 1'b0;
			res_st_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_rd_q <= 1'b0;
			out_st_q <= 1'b0;
		end else begin
			gen_v_s1 <= (state_q == ST_GEN);
			k_s1 <= k_q;
			// Drop a transferred result unless the next one takes its place
			if (out_valid_q && m_tready && (state_q != ST_RESP)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					zrow_q <= zrow_q + RW'(1);
					if (zrow_q == RW'(MAX_ROWS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_fire) begin
						res_rd_q <= 1'b0;
						res_st_q <= 1'b0;
						k_q <= '0;
						unique case (in_op)
							OP_WRITE, OP_READ: begin
								if (in_range) begin
									state_q <= ST_CELL;
								end else begin
									res_st_q <= 1'b1;
									state_q <= ST_RESP;
								end
							end
							OP_STEP: state_q <= ST_GEN;
							OP_NONE: state_q <= ST_RESP;
							default: state_q <= ST_RESP;
						endcase
					end
				end
				ST_CELL: begin
					if (!wr_op_q) begin
						res_rd_q <= mem_rdata[col_q];
					end
					state_q <= ST_RESP;
				end
				ST_GEN: begin
					k_q <= k_q + RW'(1);
					if (k_q == nr) begin
						state_q <= ST_GTAIL;
					end
				end
				ST_GTAIL: state_q <= ST_GLAST;
				ST_GLAST: begin
					zrow_q <= nr;
					state_q <= (nr == RW'(MAX_ROWS)) ? ST_RESP : ST_GZERO;
				end
				ST_GZERO: begin
					zrow_q <= zrow_q + RW'(1);
					if (zrow_q == RW'(MAX_ROWS - 1)) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_rd_q <= res_rd_q;
						out_st_q <= res_st_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold cell operands of the accepted item
	always_ff @(posedge clk) begin
		if (s_fire) begin
			wr_op_q <= (in_op == OP_WRITE);
			val_q <= in_val;
			addr_q <= AW'(in_row);
			col_q <= CAW'(in_col);
		end
	end

	// Slide the three-row window as rows come back
	always_ff @(posedge clk) begin
		if (gen_v_s1) begin
			if (k_s1 == RW'(0)) begin
				up_q <= mem_rdata;
			end else if (k_s1 == RW'(1)) begin
				cur_q <= mem_rdata;
				first_q <= mem_rdata;
			end else begin
				up_q <= cur_q;
				cur_q <= mem_rdata;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {6'b0, out_st_q, out_rd_q};

	// Never write a row in the cycle it is being read
	assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("grid row read and written in the same cycle");

	// Returned rows stay within the rows read by the sweep
	assert property (@(posedge clk) disable iff (!arst_n)
		gen_v_s1 |-> (k_s1 <= nr))
		else $error("sweep returned a row past the size in use");

	// Zeroing touches only rows past the size in use
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GZERO) |-> (zrow_q >= nr))
		else $error("zeroing pass hit a live row");

	// Clearing pass covers every row before items are taken
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_CLEAR) && (zrow_q != RW'(MAX_ROWS - 1))) |=> (state_q == ST_CLEAR))
		else $error("clearing pass ended early");

endmodule

`default_nettype wire

// ===== src/lgs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lgs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one word, read one word with registered output
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== src/lgs_row_rule.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lgs_row_rule #(
	parameter int MAX_COLS = lgs_pkg::DEF_MAX_COLS
) (
	input  wire logic [MAX_COLS-1:0]          up,
	input  wire logic [MAX_COLS-1:0]          cur,
	input  wire logic [MAX_COLS-1:0]          dn,
	input  wire logic [$clog2(MAX_COLS+1)-1:0] ncols,
	output logic      [MAX_COLS-1:0]          nxt
);
	import lgs_pkg::*;

	localparam int CW = $clog2(MAX_COLS + 1);
	localparam int CAW = $clog2(MAX_COLS);

	logic [CW-1:0]  last_w;
	logic [CAW-1:0] last_idx;

	// Last column in use closes the torus
	assign last_w = ncols - CW'(1);
	assign last_idx = last_w[CAW-1:0];

	// One lane per column
	for (genvar c = 0; c < MAX_COLS; c++) begin : g_lane
		logic up_l, up_r, cur_l, cur_r, dn_l, dn_r;
		logic at_last;
		logic [3:0] cnt;

		assign at_last = (CW'(c) == last_w);

		if (c == 0) begin : g_left_wrap
			assign up_l = up[last_idx];
			assign cur_l = cur[last_idx];
			assign dn_l = dn[last_idx];
		end else begin : g_left
			assign up_l = up[c-1];
			assign cur_l = cur[c-1];
			assign dn_l = dn[c-1];
		end

		if (c == MAX_COLS - 1) begin : g_right_edge
			assign up_r = up[0];
			assign cur_r = cur[0];
			assign dn_r = dn[0];
		end else begin : g_right
			assign up_r = at_last ? up[0] : up[c+1];
			assign cur_r = at_last ? cur[0] : cur[c+1];
			assign dn_r = at_last ? dn[0] : dn[c+1];
		end

		// Count the eight neighbors
		assign cnt = 4'(up_l) + 4'(up[c]) + 4'(up_r) + 4'(cur_l) + 4'(cur_r)
			+ 4'(dn_l) + 4'(dn[c]) + 4'(dn_r);

		// Birth or survival; columns past the size in use die
		assign nxt[c] = (CW'(c) < ncols)
			&& ((cnt == LIFE_BIRTH) || (cur[c] && (cnt == LIFE_KEEP)));
	end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// One result per item, as predicted from the grid contents at acceptance
typedef struct {
	int   seq;
	logic read_cell;
	logic status;
} cell_result_t;

class life_board;
	bit [lgs_pkg::DEF_MAX_COLS-1:0] grid [lgs_pkg::DEF_MAX_ROWS];
	logic [lgs_pkg::CFG_W-1:0] rows_reg;
	logic [lgs_pkg::CFG_W-1:0] cols_reg;
	cell_result_t pending_results [$];
	int errors;
	int checked;
	int n_items;
	int n_write;
	int n_read;
	int n_step;
	int n_spare;
	int n_oob;

	function new();
		foreach (grid[r]) grid[r] = '0;
		rows_reg = lgs_pkg::SIZE_RESET;
		cols_reg = lgs_pkg::SIZE_RESET;
	endfunction

	// Clamp a size register to the range the grid supports
	function int clamp_size(logic [lgs_pkg::CFG_W-1:0] v, int maxv);
		if (v < lgs_pkg::MIN_SIZE) return lgs_pkg::MIN_SIZE;
		if (v > maxv) return maxv;
		return int'(v);
	endfunction

	function int eff_rows();
		return clamp_size(rows_reg, lgs_pkg::DEF_MAX_ROWS);
	endfunction

	function int eff_cols();
		return clamp_size(cols_reg, lgs_pkg::DEF_MAX_COLS);
	endfunction

	function void set_reg(logic [lgs_pkg::CFG_IDX_W-1:0] idx, logic [lgs_pkg::CFG_W-1:0] v);
		if (idx == lgs_pkg::REG_GRID_ROWS) rows_reg = v;
		else if (idx == lgs_pkg::REG_GRID_COLS) cols_reg = v;
	endfunction

	// Replace the grid by its next generation on the torus in use
	function void advance_generation();
		bit [lgs_pkg::DEF_MAX_COLS-1:0] prev [lgs_pkg::DEF_MAX_ROWS];
		int nr, nc, up, dn, lf, rt, n;
		nr = eff_rows();
		nc = eff_cols();
		prev = grid;
		foreach (grid[r]) grid[r] = '0;
		for (int r = 0; r < nr; r++) begin
			up = (r == 0) ? nr - 1 : r - 1;
			dn = (r == nr - 1) ? 0 : r + 1;
			for (int c = 0; c < nc; c++) begin
				lf = (c == 0) ? nc - 1 : c - 1;
				rt = (c == nc - 1) ? 0 : c + 1;
				n = prev[up][lf] + prev[up][c] + prev[up][rt] + prev[r][lf] + prev[r][rt]
					+ prev[dn][lf] + prev[dn][c] + prev[dn][rt];
				grid[r][c] = (n == lgs_pkg::LIFE_BIRTH)
					|| (prev[r][c] && n == lgs_pkg::LIFE_KEEP);
			end
		end
	endfunction

	// Apply one accepted item and queue the result it must produce
	function void note_item(logic [1:0] op, logic [5:0] row, logic [5:0] col, logic val);
		cell_result_t res;
		res.seq = n_items;
		res.read_cell = 1'b0;
		res.status = 1'b0;
		n_items++;
		case (op)
			lgs_pkg::OP_WRITE, lgs_pkg::OP_READ: begin
				if (op == lgs_pkg::OP_WRITE) n_write++;
				else n_read++;
				if (row >= eff_rows() || col >= eff_cols()) begin
					res.status = 1'b1;
					n_oob++;
				end else if (op == lgs_pkg::OP_WRITE) begin
					grid[row][col] = val;
				end else begin
					res.read_cell = grid[row][col];
				end
			end
			lgs_pkg::OP_STEP: begin
				n_step++;
				advance_generation();
			end
			default: n_spare++;
		endcase
		pending_results.push_back(res);
	endfunction

	task report_mismatch(string msg);
		errors++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// Compare one result transfer with the oldest prediction
	task check_result(logic rd, logic st);
		cell_result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch($sformatf("result rd=%0b st=%0b with nothing pending", rd, st));
		end else begin
			want = pending_results.pop_front();
			checked++;
			if (rd !== want.read_cell)
				report_mismatch($sformatf("item %0d read_cell %0b, want %0b",
					want.seq, rd, want.read_cell));
			if (st !== want.status)
				report_mismatch($sformatf("item %0d status %0b, want %0b",
					want.seq, st, want.status));
		end
	endtask
endclass

module tb;

	localparam int SETTLE_CYCLES = lgs_pkg::DEF_MAX_ROWS + 8;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int PHASE_ITEMS = 163;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [lgs_pkg::IN_DATA_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [lgs_pkg::OUT_DATA_W-1:0] m_tdata;
	logic cfg_we;
	logic [lgs_pkg::CFG_IDX_W-1:0] cfg_addr;
	logic [lgs_pkg::CFG_W-1:0] cfg_wdata;

	life_board sb;
	bit calm;
	int n_sizes;

	life_grid_generation_step i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offer one item, at times after a random gap, and hold it until the transfer
	task automatic offer(logic [1:0] op, logic [5:0] row, logic [5:0] col, logic val);
		if (!calm && $urandom_range(99) < 14) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, val, col, row, op};
		do @(posedge clk); while (!s_tready);
		sb.note_item(op, row, col, val);
	endtask

	// Drop valid, wait for every result, then let the block go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_size(logic [lgs_pkg::CFG_W-1:0] rows_v, logic [lgs_pkg::CFG_W-1:0] cols_v);
		cfg_we <= 1'b1;
		cfg_addr <= lgs_pkg::REG_GRID_ROWS;
		cfg_wdata <= rows_v;
		@(posedge clk);
		cfg_addr <= lgs_pkg::REG_GRID_COLS;
		cfg_wdata <= cols_v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(lgs_pkg::REG_GRID_ROWS, rows_v);
		sb.set_reg(lgs_pkg::REG_GRID_COLS, cols_v);
		n_sizes++;
	endtask

	// Seed a window of the torus, then mix reads, writes, steps and noise
	task automatic run_phase(logic [lgs_pkg::CFG_W-1:0] rows_v,
			logic [lgs_pkg::CFG_W-1:0] cols_v, int count);
		int nr, nc, wr, wc, org_r, org_c, pick;
		logic [5:0] r, c;
		settle();
		set_size(rows_v, cols_v);
		nr = sb.eff_rows();
		nc = sb.eff_cols();
		wr = (nr < 12) ? nr : 12;
		wc = (nc < 12) ? nc : 12;
		org_r = $urandom_range(nr - 1);
		org_c = $urandom_range(nc - 1);
		for (int k = 0; k < count; k++) begin
			r = 6'((org_r + $urandom_range(wr - 1)) % nr);
			c = 6'((org_c + $urandom_range(wc - 1)) % nc);
			pick = $urandom_range(99);
			if (k < count / 4)
				offer(lgs_pkg::OP_WRITE, r, c, $urandom_range(99) < 45);
			else if (pick < 40)
				offer(lgs_pkg::OP_READ, r, c, 1'($urandom_range(1)));
			else if (pick < 58)
				offer(lgs_pkg::OP_WRITE, r, c, 1'($urandom_range(1)));
			else if (pick < 74)
				offer(lgs_pkg::OP_STEP, 6'($urandom_range(63)), 6'($urandom_range(63)),
					1'($urandom_range(1)));
			else if (pick < 82)
				offer(lgs_pkg::OP_READ, 6'($urandom_range(63)), 6'($urandom_range(63)),
					1'($urandom_range(1)));
			else if (pick < 90)
				offer(lgs_pkg::OP_WRITE, 6'($urandom_range(63)), 6'($urandom_range(63)),
					1'($urandom_range(1)));
			else
				offer(lgs_pkg::OP_NONE, 6'($urandom_range(63)), 6'($urandom_range(63)),
					1'($urandom_range(1)));
		end
	endtask

	// Take results, stall at random, and hold off once for a long stretch
	initial begin : result_sink
		int hold;
		bit held;
		hold = 0;
		held = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) sb.check_result(m_tdata[0], m_tdata[1]);
			if (!held && sb.n_items >= 100) begin
				held = 1;
				hold = HOLD_OFF_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= calm || ($urandom_range(99) >= 14);
			end
		end
	end

	initial begin : watchdog
		#(10_000_000);
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		logic [lgs_pkg::CFG_W-1:0] rv, cv;
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		calm = 1'b0;
		n_sizes = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Four corners form a block across both wraps; it must survive a step
		offer(lgs_pkg::OP_WRITE, 6'd0, 6'd0, 1'b1);
		offer(lgs_pkg::OP_WRITE, 6'd63, 6'd63, 1'b1);
		offer(lgs_pkg::OP_WRITE, 6'd0, 6'd63, 1'b1);
		offer(lgs_pkg::OP_WRITE, 6'd63, 6'd0, 1'b1);
		offer(lgs_pkg::OP_READ, 6'd63, 6'd63, 1'b0);
		offer(lgs_pkg::OP_READ, 6'd31, 6'd31, 1'b1);
		offer(lgs_pkg::OP_STEP, 6'd0, 6'd0, 1'b0);
		offer(lgs_pkg::OP_READ, 6'd0, 6'd0, 1'b0);
		offer(lgs_pkg::OP_READ, 6'd63, 6'd63, 1'b0);
		offer(lgs_pkg::OP_READ, 6'd0, 6'd63, 1'b0);
		offer(lgs_pkg::OP_READ, 6'd63, 6'd0, 1'b0);
		offer(lgs_pkg::OP_NONE, 6'd63, 6'd63, 1'b1);
		// Horizontal blinker straddling the column wrap turns vertical
		offer(lgs_pkg::OP_WRITE, 6'd10, 6'd63, 1'b1);
		offer(lgs_pkg::OP_WRITE, 6'd10, 6'd0, 1'b1);
		offer(lgs_pkg::OP_WRITE, 6'd10, 6'd1, 1'b1);
		offer(lgs_pkg::OP_STEP, 6'd63, 6'd63, 1'b1);
		offer(lgs_pkg::OP_READ, 6'd9, 6'd0, 1'b0);
		offer(lgs_pkg::OP_READ, 6'd11, 6'd0, 1'b0);
		offer(lgs_pkg::OP_READ, 6'd10, 6'd63, 1'b0);

		// Smallest torus: accesses past the size in use report a range error; then an in-range read and a step
		settle();
		set_size(7'd3, 7'd3);
		offer(lgs_pkg::OP_WRITE, 6'd3, 6'd0, 1'b1);
		offer(lgs_pkg::OP_READ, 6'd0, 6'd3, 1'b0);
		offer(lgs_pkg::OP_READ, 6'd63, 6'd63, 1'b0);
		offer(lgs_pkg::OP_READ, 6'd0, 6'd0, 1'b0);
		offer(lgs_pkg::OP_STEP, 6'd0, 6'd0, 1'b0);

		// Random phases over extreme, clamped and ordinary sizes
		for (int p = 0; p < 10; p++) begin
			case (p)
				0: begin rv = 7'd3;   cv = 7'd3;   end
				1: begin rv = 7'd0;   cv = 7'd127; end
				2: begin rv = 7'd127; cv = 7'd0;   end
				3: begin rv = 7'd64;  cv = 7'd64;  end
				4: begin rv = 7'd5;   cv = 7'd7;   end
				5: begin rv = 7'd8;   cv = 7'd8;   end
				8: begin rv = 7'd2;   cv = 7'd1;   end
				9: begin rv = 7'd64;  cv = 7'd64;  end
				default: begin
					rv = 7'($urandom_range(3, 16));
					cv = 7'($urandom_range(3, 16));
				end
			endcase
			calm = (p == 3);
			run_phase(rv, cv, PHASE_ITEMS);
		end
		calm = 1'b0;

		settle();
		$display("Covered %0d writes, %0d reads, %0d generation steps, %0d unused-op items",
			sb.n_write, sb.n_read, sb.n_step, sb.n_spare);
		$display("%0d results checked over %0d grid sizes, %0d out-of-range accesses",
			sb.checked, n_sizes, sb.n_oob);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
